// ===== design/lpdr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpdr_pkg
// Shared types and constants of the length-prefixed deframer with marker
// resynchronisation.
// ----------------------------------------------------------------------------
package lpdr_pkg;

   localparam int unsigned FIELD_BITS = 16;

   localparam logic [FIELD_BITS-1:0] MAX_LENGTH_RESET = 16'd2000;

   localparam logic [7:0] MARKER_S    = 8'h73;
   localparam logic [7:0] MARKER_R    = 8'h72;
   localparam logic [7:0] MARKER_ZERO = 8'h30;
   localparam logic [7:0] MARKER_ONE  = 8'h31;

   typedef struct packed {
      logic                  last_of_packet;
      logic [FIELD_BITS-1:0] frame_length;
      logic [FIELD_BITS-1:0] byte_index;
      logic [7:0]            payload_byte;
   } result_type;

endpackage

// ===== design/length_prefixed_deframer_resync_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_deframer_resync_unit
// Byte-stream deframer: two-byte little-endian length, then payload bytes
// tagged with index, length and last flag; marker hunt on bad lengths.
// ----------------------------------------------------------------------------
// One stream byte is taken every cycle while the result side keeps up. An
// accepted byte is held in the input register and is stepped through
// lpdr_core once the output register is free; a payload step loads its
// result into the output register, which drives rsp_tvalid. While an untaken
// result holds the output register the step stalls, and the input register
// holds at most one waiting byte. Length bytes and hunted bytes yield no
// transaction.
// max_length (reset 2000) must be written only while the block is idle.
module length_prefixed_deframer_resync_unit #(
   parameter int unsigned LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] payload_byte, [23:8] byte_index,
                                    // [39:24] frame_length
   output logic        rsp_tlast,   // last_of_packet
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // max_length
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lpdr_pkg::result_type rsp_ff;
   logic [15:0]          max_length_ff;
   logic                 out_free;
   logic                 step_en;
   logic                 req_fire;
   logic                 core_valid;
   lpdr_pkg::result_type core_res;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !in_valid_ff || out_free;
   assign req_fire    = req_tvalid && req_tready;
   assign step_en     = in_valid_ff && out_free;
   assign in_valid_in = req_fire || (in_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? (step_en && core_valid) : 1'b1;

   lpdr_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .step_byte  (in_byte_ff),
      .max_length (max_length_ff),
      .res_valid  (core_valid),
      .res        (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_length_ff <= lpdr_pkg::MAX_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_length_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
      if (step_en && core_valid) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.frame_length, rsp_ff.byte_index, rsp_ff.payload_byte};
   assign rsp_tlast  = rsp_ff.last_of_packet;

endmodule

// ===== design/lpdr_core.sv =====
// ----------------------------------------------------------------------------
// lpdr_core
// Per-byte state update: length assembly, payload tagging and marker hunt.
// ----------------------------------------------------------------------------
module lpdr_core #(
   parameter int unsigned LENGTH_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [7:0]                        step_byte,
   input  logic [lpdr_pkg::FIELD_BITS-1:0]   max_length,
   output logic                              res_valid,
   output lpdr_pkg::result_type              res
);

   typedef enum logic [1:0] {
      MODE_LEN_LO,
      MODE_LEN_HI,
      MODE_PAYLOAD,
      MODE_HUNT
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [7:0]             low_ff, low_in;
   logic [LENGTH_BITS-1:0] held_ff, held_in;
   logic [LENGTH_BITS-1:0] taken_ff, taken_in;
   logic [1:0]             progress_ff, progress_in;

   logic [2*8-1:0]         raw_length;
   logic [LENGTH_BITS-1:0] assembled;
   logic                   length_ok;
   logic [LENGTH_BITS:0]   taken_next;
   logic                   last;
   logic [2:0]             feed_low;
   logic [2:0]             feed_high;
   logic [2:0]             feed_hunt;

   function automatic logic [2:0] marker_feed(input logic [1:0] prog, input logic [7:0] ch);
      logic [2:0] r;
      r = 3'b000;
      case (prog)
         2'd0: r = {1'b0, (ch == lpdr_pkg::MARKER_S)    ? 2'd1 : 2'd0};
         2'd1: r = {1'b0, (ch == lpdr_pkg::MARKER_R)    ? 2'd2 : 2'd0};
         2'd2: r = {1'b0, (ch == lpdr_pkg::MARKER_ZERO) ? 2'd3 : 2'd0};
         default: r = {(ch == lpdr_pkg::MARKER_ZERO) || (ch == lpdr_pkg::MARKER_ONE), 2'd0};
      endcase
      return r;
   endfunction

   assign raw_length = {step_byte, low_ff};
   assign assembled  = raw_length[LENGTH_BITS-1:0];
   assign length_ok  = (assembled != '0) &&
                       (lpdr_pkg::FIELD_BITS'(assembled) <= max_length);
   assign taken_next = {1'b0, taken_ff} + (LENGTH_BITS+1)'(1);
   assign last       = taken_next >= {1'b0, held_ff};
   assign feed_low   = marker_feed(2'd0, low_ff);
   assign feed_high  = marker_feed(feed_low[1:0], step_byte);
   assign feed_hunt  = marker_feed(progress_ff, step_byte);

   always_comb begin
      mode_in     = mode_ff;
      low_in      = low_ff;
      held_in     = held_ff;
      taken_in    = taken_ff;
      progress_in = progress_ff;
      res_valid   = 1'b0;
      res.payload_byte   = step_byte;
      res.byte_index     = lpdr_pkg::FIELD_BITS'(taken_ff);
      res.frame_length   = lpdr_pkg::FIELD_BITS'(held_ff);
      res.last_of_packet = last;
      if (step_en) begin
         case (mode_ff)
            MODE_LEN_LO: begin
               low_in  = step_byte;
               mode_in = MODE_LEN_HI;
            end
            MODE_LEN_HI: begin
               held_in = assembled;
               if (length_ok) begin
                  taken_in = '0;
                  mode_in  = MODE_PAYLOAD;
               end else begin
                  progress_in = feed_high[1:0];
                  mode_in     = MODE_HUNT;
               end
            end
            MODE_PAYLOAD: begin
               res_valid = 1'b1;
               if (last) begin
                  taken_in = '0;
                  mode_in  = MODE_LEN_LO;
               end else begin
                  taken_in = taken_next[LENGTH_BITS-1:0];
               end
            end
            default: begin
               progress_in = feed_hunt[1:0];
               if (feed_hunt[2]) begin
                  mode_in = MODE_LEN_LO;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_LEN_LO;
         low_ff      <= '0;
         held_ff     <= '0;
         taken_ff    <= '0;
         progress_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         low_ff      <= low_in;
         held_ff     <= held_in;
         taken_ff    <= taken_in;
         progress_ff <= progress_in;
      end
   end

`ifndef SYNTHESIS
   a_payload_in_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_PAYLOAD |-> (held_ff != '0) && (taken_ff < held_ff))
      else $error("payload counter outside packet length");

   a_progress_only_hunting: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_HUNT |-> progress_ff == 2'd0)
      else $error("marker progress held outside hunt");

   a_result_only_payload: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> step_en && (mode_ff == MODE_PAYLOAD))
      else $error("result outside payload");

   a_last_returns_to_length: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last_of_packet |=> mode_ff == MODE_LEN_LO)
      else $error("final byte did not return to length read");

   a_reject_starts_hunt: assert property (@(posedge clock) disable iff (reset)
      step_en && (mode_ff == MODE_LEN_HI) && !length_ok |=> mode_ff == MODE_HUNT)
      else $error("rejected length did not start hunt");
`endif

endmodule
